/* src/box_average_image_scaler_defines.svh */
// Assertion macros for the box average image scaler.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef BOX_AVERAGE_IMAGE_SCALER_DEFINES_SVH
`define BOX_AVERAGE_IMAGE_SCALER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAIS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bais check failed");

// The consequent must hold in the cycle after the antecedent.
`define BAIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bais check failed");

`endif

/* src/bais_pkg.sv */
// Shared types, register indexes and constants of the box average image scaler.
// No dependencies; imported by the interfaces and the top level.
`default_nettype none
package bais_pkg;
   localparam int DEF_MAX_SOURCE_WIDTH  = 256;
   localparam int DEF_MAX_SOURCE_HEIGHT = 256;
   localparam int DEF_MAX_OUTPUT_SIZE   = 4096;

   localparam int SAMPLE_W  = 16;
   localparam int COORD_W   = 8;
   localparam int DEST_W    = 12;
   localparam int SRC_CFG_W = 9;
   localparam int OUT_CFG_W = 13;
   localparam int SHB_W     = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 13;
   localparam int SHIFT_W   = 5;
   localparam int NRM_W     = SAMPLE_W + 7;

   localparam logic [SHB_W-1:0] SHB_REF = 4'd7;
   localparam logic [7:0]       BYTE_MASK = 8'hff;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [7:0]          byte_type;

   typedef struct packed {
      sample_type a;
      sample_type b;
      sample_type c;
   } pixel_type;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_RENDER = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_HIGH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_THREE_CHANNEL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BLUE_FIRST    = 3'd6;
endpackage
`default_nettype wire

/* src/bais_ifs.sv */
// Valid/ready channel interfaces for scaler requests and responses.
// Depends on bais_pkg for the payload types.
`default_nettype none
interface bais_req_if;
   import bais_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [COORD_W-1:0]    source_col;
   logic [COORD_W-1:0]    source_row;
   sample_type            sample_a;
   sample_type            sample_b;
   sample_type            sample_c;
   logic [DEST_W-1:0]     dest_col;
   logic [DEST_W-1:0]     dest_row;

   modport source (output valid, mode, source_col, source_row, sample_a, sample_b,
                   sample_c, dest_col, dest_row, input ready);
   modport sink (input valid, mode, source_col, source_row, sample_a, sample_b,
                 sample_c, dest_col, dest_row, output ready);
endinterface

interface bais_rsp_if;
   import bais_pkg::*;
   logic     valid;
   logic     ready;
   byte_type byte_first;
   byte_type byte_second;
   byte_type byte_third;
   logic     empty_box;

   modport source (output valid, byte_first, byte_second, byte_third, empty_box,
                   input ready);
   modport sink (input valid, byte_first, byte_second, byte_third, empty_box,
                 output ready);
endinterface
`default_nettype wire

/* src/box_average_image_scaler.sv */
// A load beat is written to the pixel store as it is accepted. A render beat first
// finds the box bounds, then walks the box through the pixel store one virtual pixel
// at a time (one read port, one read a cycle), then computes the averages; bounds and
// averages use the shared one-bit-a-cycle divider of width NUM_W (51 at the defaults).
// Setup before the bounds includes the scale shifts.
// Top level: pixel store, sequencer and shared divider. Uses bais_pkg, bais_ifs
// and the assertion macros of box_average_image_scaler_defines.svh.
`default_nettype none
`include "box_average_image_scaler_defines.svh"
module box_average_image_scaler #(
   parameter int MAX_SOURCE_WIDTH  = bais_pkg::DEF_MAX_SOURCE_WIDTH,
   parameter int MAX_SOURCE_HEIGHT = bais_pkg::DEF_MAX_SOURCE_HEIGHT,
   parameter int MAX_OUTPUT_SIZE   = bais_pkg::DEF_MAX_OUTPUT_SIZE
) (
   input  wire                                 clock,
   input  wire                                 reset,
   bais_req_if.sink                            req_if,
   bais_rsp_if.source                          rsp_if,
   input  wire                                 csr_we,
   input  wire [bais_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [bais_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import bais_pkg::*;

   localparam int CW      = $clog2(MAX_SOURCE_WIDTH);
   localparam int RW      = $clog2(MAX_SOURCE_HEIGHT);
   localparam int AW      = CW + RW;
   localparam int DEPTH   = 2 ** AW;
   localparam int VMAX_A  = MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT ?
                            MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT;
   localparam int VMAX    = VMAX_A > 2 * MAX_OUTPUT_SIZE ? VMAX_A : 2 * MAX_OUTPUT_SIZE;
   localparam int VW_W    = $clog2(VMAX + 1);
   localparam int CNT_W   = 2 * VW_W;
   localparam int SUM_W   = NRM_W + CNT_W;
   localparam int PROD_W  = OUT_CFG_W + VW_W;
   localparam int NUM_W   = SUM_W;
   localparam int DEN_W   = CNT_W;
   localparam int DCNT_W  = $clog2(NUM_W + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SHIFT = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_LDIV  = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_POST  = 4'd5;
   localparam logic [3:0] ST_COUNT = 4'd6;
   localparam logic [3:0] ST_WALK  = 4'd7;
   localparam logic [3:0] ST_DRAIN = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   pixel_type mem [DEPTH];

   logic [3:0]            state_ff, state_in;
   logic [SRC_CFG_W-1:0]  sw_ff, sw_in, sh_ff, sh_in;
   logic [OUT_CFG_W-1:0]  otw_ff, otw_in, oth_ff, oth_in;
   logic [SHB_W-1:0]      shb_ff, shb_in;
   logic                  tc_ff, tc_in, bf_ff, bf_in;
   logic [DEST_W-1:0]     dc_ff, dc_in, dr_ff, dr_in;
   logic [VW_W-1:0]       vw_ff, vw_in, vh_ff, vh_in;
   logic [SHIFT_W-1:0]    sx_ff, sx_in, sy_ff, sy_in;
   logic [1:0]            k_ff, k_in;
   logic                  avgph_ff, avgph_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [NUM_W-1:0]      nq_ff, nq_in;
   logic [DEN_W-1:0]      rem_ff, rem_in, den_ff, den_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic [VW_W-1:0]       fx_ff, fx_in, lx_ff, lx_in, fy_ff, fy_in, ly_ff, ly_in;
   logic [VW_W-1:0]       vx_ff, vx_in, vy_ff, vy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SUM_W-1:0]      sum_ff [3];
   logic [SUM_W-1:0]      sum_in [3];
   byte_type              avg_ff [3];
   byte_type              avg_in [3];
   logic                  empty_ff, empty_in;
   logic                  rd_vld_ff;
   pixel_type             rd_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   byte_type              b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic                  eb_ff, eb_in;

   logic [VW_W-1:0]       w_c, h_c, otw_c, oth_c;
   logic [SHB_W-1:0]      rs, ls;
   logic                  accept, mem_we, mem_re;
   logic [AW-1:0]         waddr, raddr;
   logic [OUT_CFG_W-1:0]  mul_a;
   logic [VW_W-1:0]       mul_b;
   logic [DEN_W:0]        trial;
   logic                  ge;
   logic [NRM_W-1:0]      norm [3];
   sample_type            rd_ch [3];

   assign w_c   = (32'(sw_ff) > MAX_SOURCE_WIDTH) ? VW_W'(MAX_SOURCE_WIDTH) : VW_W'(sw_ff);
   assign h_c   = (32'(sh_ff) > MAX_SOURCE_HEIGHT) ? VW_W'(MAX_SOURCE_HEIGHT) : VW_W'(sh_ff);
   assign otw_c = (32'(otw_ff) > MAX_OUTPUT_SIZE) ? VW_W'(MAX_OUTPUT_SIZE) : VW_W'(otw_ff);
   assign oth_c = (32'(oth_ff) > MAX_OUTPUT_SIZE) ? VW_W'(MAX_OUTPUT_SIZE) : VW_W'(oth_ff);
   assign rs    = (shb_ff > SHB_REF) ? shb_ff - SHB_REF : '0;
   assign ls    = (shb_ff < SHB_REF) ? SHB_REF - shb_ff : '0;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign mem_we       = accept && (req_if.mode == MODE_LOAD) &&
                         (32'(req_if.source_col) < MAX_SOURCE_WIDTH) &&
                         (32'(req_if.source_row) < MAX_SOURCE_HEIGHT);
   assign waddr        = {RW'(req_if.source_row), CW'(req_if.source_col)};
   assign mem_re       = (state_ff == ST_WALK);
   assign raddr        = {RW'(vy_ff >> sy_ff), CW'(vx_ff >> sx_ff)};

   assign mul_a = (k_ff[1] ? OUT_CFG_W'(dr_ff) : OUT_CFG_W'(dc_ff)) + OUT_CFG_W'(k_ff[0]);
   assign mul_b = k_ff[1] ? vh_ff : vw_ff;
   assign trial = {rem_ff, nq_ff[NUM_W-1]};
   assign ge    = (trial >= {1'b0, den_ff});

   assign rd_ch[0] = rd_data_ff.a;
   assign rd_ch[1] = rd_data_ff.b;
   assign rd_ch[2] = rd_data_ff.c;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         norm[i] = NRM_W'(rd_ch[i] >> rs) << ls;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= '{a: req_if.sample_a, b: req_if.sample_b, c: req_if.sample_c};
      end
      if (mem_re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sw_in        = sw_ff;
      sh_in        = sh_ff;
      otw_in       = otw_ff;
      oth_in       = oth_ff;
      shb_in       = shb_ff;
      tc_in        = tc_ff;
      bf_in        = bf_ff;
      dc_in        = dc_ff;
      dr_in        = dr_ff;
      vw_in        = vw_ff;
      vh_in        = vh_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      k_in         = k_ff;
      avgph_in     = avgph_ff;
      prod_in      = prod_ff;
      nq_in        = nq_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      dcnt_in      = dcnt_ff;
      fx_in        = fx_ff;
      lx_in        = lx_ff;
      fy_in        = fy_ff;
      ly_in        = ly_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      eb_in        = eb_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_SOURCE_WIDTH:  sw_in  = SRC_CFG_W'(csr_wdata);
            REG_SOURCE_HEIGHT: sh_in  = SRC_CFG_W'(csr_wdata);
            REG_OUTPUT_WIDTH:  otw_in = OUT_CFG_W'(csr_wdata);
            REG_OUTPUT_HEIGHT: oth_in = OUT_CFG_W'(csr_wdata);
            REG_SAMPLE_HIGH:   shb_in = SHB_W'(csr_wdata);
            REG_THREE_CHANNEL: tc_in  = csr_wdata[0];
            REG_BLUE_FIRST:    bf_in  = csr_wdata[0];
            default: ;
         endcase
      end

      for (int i = 0; i < 3; i++) begin
         if (rd_vld_ff) begin
            sum_in[i] = sum_ff[i] + SUM_W'(norm[i]);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_if.mode == MODE_RENDER) begin
               dc_in = req_if.dest_col;
               dr_in = req_if.dest_row;
               vw_in = w_c;
               vh_in = h_c;
               sx_in = '0;
               sy_in = '0;
               k_in  = '0;
               avgph_in = 1'b0;
               if (w_c == '0 || h_c == '0 || otw_c == '0 || oth_c == '0 ||
                   32'(req_if.dest_col) >= 32'(otw_c) ||
                   32'(req_if.dest_row) >= 32'(oth_c)) begin
                  empty_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  empty_in = 1'b0;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (vw_ff < otw_c) begin
               vw_in = vw_ff << 1;
               sx_in = sx_ff + 1'b1;
            end
            if (vh_ff < oth_c) begin
               vh_in = vh_ff << 1;
               sy_in = sy_ff + 1'b1;
            end
            if (vw_ff >= otw_c && vh_ff >= oth_c) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in = ST_LDIV;
         end
         ST_LDIV: begin
            if (avgph_ff) begin
               nq_in  = sum_ff[k_ff];
               den_in = cnt_ff;
            end else begin
               nq_in  = NUM_W'(prod_ff);
               den_in = k_ff[1] ? DEN_W'(oth_c) : DEN_W'(otw_c);
            end
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
            nq_in   = {nq_ff[NUM_W-2:0], ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (32'(dcnt_ff) == NUM_W - 1) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (avgph_ff) begin
               avg_in[k_ff] = nq_ff[7:0] & BYTE_MASK;
               if (k_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_LDIV;
               end
            end else begin
               unique case (k_ff)
                  2'd0: fx_in = VW_W'(nq_ff);
                  2'd1: lx_in = VW_W'(nq_ff);
                  2'd2: fy_in = VW_W'(nq_ff);
                  default: ly_in = VW_W'(nq_ff);
               endcase
               if (k_ff == 2'd3) begin
                  state_in = ST_COUNT;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_COUNT: begin
            cnt_in = CNT_W'(lx_ff - fx_ff) * CNT_W'(ly_ff - fy_ff);
            vx_in  = fx_ff;
            vy_in  = fy_ff;
            for (int i = 0; i < 3; i++) begin
               sum_in[i] = '0;
            end
            if (lx_ff <= fx_ff || ly_ff <= fy_ff) begin
               empty_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (vx_ff == lx_ff - 1'b1) begin
               vx_in = fx_ff;
               vy_in = vy_ff + 1'b1;
               if (vy_ff == ly_ff - 1'b1) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               vx_in = vx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff) begin
               avgph_in = 1'b1;
               k_in     = '0;
               state_in = ST_LDIV;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               eb_in        = empty_ff;
               if (empty_ff) begin
                  b1_in = '0;
                  b2_in = '0;
                  b3_in = '0;
               end else if (!tc_ff) begin
                  b1_in = avg_ff[0];
                  b2_in = avg_ff[0];
                  b3_in = avg_ff[0];
               end else if (bf_ff) begin
                  b1_in = avg_ff[2];
                  b2_in = avg_ff[1];
                  b3_in = avg_ff[0];
               end else begin
                  b1_in = avg_ff[0];
                  b2_in = avg_ff[1];
                  b3_in = avg_ff[2];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sw_ff        <= SRC_CFG_W'(1);
         sh_ff        <= SRC_CFG_W'(1);
         otw_ff       <= OUT_CFG_W'(1);
         oth_ff       <= OUT_CFG_W'(1);
         shb_ff       <= SHB_REF;
         tc_ff        <= 1'b0;
         bf_ff        <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         sh_ff        <= sh_in;
         otw_ff       <= otw_in;
         oth_ff       <= oth_in;
         shb_ff       <= shb_in;
         tc_ff        <= tc_in;
         bf_ff        <= bf_in;
         rd_vld_ff    <= mem_re;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dc_ff    <= dc_in;
      dr_ff    <= dr_in;
      vw_ff    <= vw_in;
      vh_ff    <= vh_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      k_ff     <= k_in;
      avgph_ff <= avgph_in;
      prod_ff  <= prod_in;
      nq_ff    <= nq_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      dcnt_ff  <= dcnt_in;
      fx_ff    <= fx_in;
      lx_ff    <= lx_in;
      fy_ff    <= fy_in;
      ly_ff    <= ly_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      cnt_ff   <= cnt_in;
      sum_ff   <= sum_in;
      avg_ff   <= avg_in;
      empty_ff <= empty_in;
      b1_ff    <= b1_in;
      b2_ff    <= b2_in;
      b3_ff    <= b3_in;
      eb_ff    <= eb_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.byte_first  = b1_ff;
   assign rsp_if.byte_second = b2_ff;
   assign rsp_if.byte_third  = b3_ff;
   assign rsp_if.empty_box   = eb_ff;

   `BAIS_ASSERT_NEXT(a_walk_read, clock, reset, state_ff == ST_WALK, rd_vld_ff)
   `BAIS_ASSERT_NOW(a_walk_box, clock, reset, state_ff == ST_WALK,
                    vx_ff < lx_ff && vy_ff < ly_ff)
   `BAIS_ASSERT_NOW(a_div_rem, clock, reset, state_ff == ST_DIV, rem_ff < den_ff)
   `BAIS_ASSERT_NEXT(a_done_hold, clock, reset,
                     state_ff == ST_DONE && rsp_valid_ff && !rsp_if.ready,
                     state_ff == ST_DONE)
endmodule
`default_nettype wire
